// ----- rtl/core/periodic_task_slot_scheduler_assert.svh -----
// Assertion macros for the periodic task slot scheduler.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PTS_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PTS_ASSERT_NXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);
`endif

// ----- rtl/core/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes of the periodic task slot scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;
    localparam logic [2:0] MODE_TICK   = 3'd0;
    localparam logic [2:0] MODE_ADD    = 3'd1;
    localparam logic [2:0] MODE_DEL    = 3'd2;
    localparam logic [2:0] MODE_EN     = 3'd3;
    localparam logic [2:0] MODE_PER    = 3'd4;
    localparam logic [2:0] MODE_REPL   = 3'd5;
    localparam logic [2:0] MODE_CLEAR  = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NONE     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam int RESULT_CAP = 16;

    // one slot word handed along the chain
    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] period;
        logic [31:0] last_run;
        logic        enabled;
    } t_slot;

    // operation applied by the cell at the chain head
    typedef struct packed {
        logic        wr;      // replace head slot with wdata
        logic        shift;   // rotate chain by one
    } t_ctrl;
endpackage

// ----- rtl/core/pts_cell.sv -----
// ----------------------------------------------------------------------------
// pts_cell
// One slot register of the rotating slot chain.
// ----------------------------------------------------------------------------
module pts_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  pts_pkg::t_slot i_prev,
    output pts_pkg::t_slot o_slot
);
    import pts_pkg::*;

    t_slot r_slot;

    // advance: take the neighbor's word
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_slot <= i_prev;
        end
    end

    assign o_slot = r_slot;
endmodule

// ----- rtl/core/pts_chain.sv -----
// ----------------------------------------------------------------------------
// pts_chain
// Ring of slot cells; slot at the head is visible and may be rewritten.
// ----------------------------------------------------------------------------
module pts_chain #(
    parameter int MAX_SLOTS = 16
) (
    input  logic           i_clk,
    input  pts_pkg::t_ctrl i_ctrl,
    input  pts_pkg::t_slot i_wdata,
    output pts_pkg::t_slot o_head
);
    import pts_pkg::*;

    t_slot w_q [MAX_SLOTS];
    t_slot w_d [MAX_SLOTS];

    // tail cell feeds back from the head, or takes the rewritten word
    always_comb begin
        for (int k = 0; k < MAX_SLOTS; k++) begin
            w_d[k] = w_q[(k + 1) % MAX_SLOTS];
        end
        w_d[MAX_SLOTS-1] = i_ctrl.wr ? i_wdata : w_q[0];
    end

    for (genvar g = 0; g < MAX_SLOTS; g++) begin : g_cell
        pts_cell u_cell (
            .i_clk  (i_clk),
            .i_shift(i_ctrl.shift),
            .i_prev (w_d[g]),
            .o_slot (w_q[g])
        );
    end

    assign o_head = w_q[0];
endmodule

// ----- rtl/core/periodic_task_slot_scheduler.sv -----
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler
// Table of periodic task slots with tick scan, append, id lookup and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: raise i_start with mode and operands while o_busy is
//    low; the word is taken at that edge and o_busy rises next cycle.
//  - Result channel: o_valid marks each result word for one cycle; the
//    receiver cannot stall, so every word must be taken when shown.
//    o_last flags the final word of a command.
//  - Slots live in a ring of MAX_SLOTS cells that rotates one place per
//    cycle while a command walks it. Every command except mode 7 walks
//    the full ring once and then passes S_DONE before o_busy falls,
//    whatever the result count.
//  - Tick results come out during the walk, one per due slot, but the last
//    one and the single word of other commands (and none-due) come at the end of the walk.
//  - Mode 7 is not taken: it gives no word and o_busy stays low.
//  - Configuration: i_cfg_we with i_cfg_wdata writes the limit (r_limit) at once;
//    write it only while idle.
//  - Reset (i_rst_n low, synchronous) empties the table and sets the limit
//    to 16. Slot contents are not cleared; the used count guards them.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler #(
    parameter int MAX_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_task_id,
    input  logic [15:0] i_new_task_id,
    input  logic [15:0] i_period_ms,
    input  logic        i_enable,
    output logic        o_valid,
    output logic [15:0] o_due_task,
    output logic [3:0]  o_slot_index,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import pts_pkg::*;

    localparam int IW = $clog2(MAX_SLOTS);
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} t_state;

    t_state      r_state;
    logic [4:0]  r_limit;
    logic [CW-1:0] r_used;
    logic [IW-1:0] r_pos;
    logic [2:0]  r_mode;
    logic [31:0] r_now;
    logic [15:0] r_id, r_new_id, r_period;
    logic        r_en;
    logic        r_found;
    logic [IW-1:0] r_hit;
    logic [4:0]  r_cnt;      // tick results given so far
    logic        r_pend;     // a due word is waiting for its successor
    logic [15:0] r_pend_task;
    logic [IW-1:0] r_pend_idx;
    logic        r_valid, r_last;
    logic [15:0] r_otask;
    logic [3:0]  r_oidx;
    logic [1:0]  r_ostat;

    t_slot w_head, w_wdata;
    t_ctrl w_ctrl;
    logic  w_inuse, w_match, w_due;
    logic [CW-1:0] w_lim;
    logic [31:0] w_elapsed;

    pts_chain #(.MAX_SLOTS(MAX_SLOTS)) u_chain (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_wdata(w_wdata),
        .o_head (w_head)
    );

    assign w_lim = (r_limit > 5'(MAX_SLOTS > 31 ? 31 : MAX_SLOTS))
                 ? CW'(MAX_SLOTS) : CW'(r_limit);
    assign w_inuse   = CW'(r_pos) < r_used;
    assign w_match   = w_inuse && !r_found && (w_head.task_id == r_id);
    assign w_elapsed = r_now - w_head.last_run;
    assign w_due     = w_inuse && (w_head.task_id != 16'd0) && w_head.enabled
                     && (w_elapsed > {16'd0, w_head.period})
                     && (r_cnt < 5'(RESULT_CAP));

    // head rewrite for the current slot
    always_comb begin
        w_wdata      = w_head;
        w_ctrl.shift = (r_state == S_WALK);
        w_ctrl.wr    = 1'b0;
        if (r_state == S_WALK) begin
            case (r_mode)
                MODE_TICK: begin
                    if (w_due) begin
                        w_ctrl.wr = 1'b1;
                        w_wdata.last_run = r_now;
                    end
                end
                MODE_ADD: begin
                    if (CW'(r_pos) == r_used && r_used < w_lim) begin
                        w_ctrl.wr = 1'b1;
                        w_wdata = '{task_id: r_id, period: r_period,
                                    last_run: 32'd0, enabled: r_en};
                    end
                end
                MODE_DEL: if (w_match) begin
                    w_ctrl.wr = 1'b1;
                    w_wdata.task_id = 16'd0;
                end
                MODE_EN: if (w_match) begin
                    w_ctrl.wr = 1'b1;
                    w_wdata.enabled = r_en;
                end
                MODE_PER: if (w_match) begin
                    w_ctrl.wr = 1'b1;
                    w_wdata.period = r_period;
                    w_wdata.last_run = r_now;
                end
                MODE_REPL: if (w_match) begin
                    w_ctrl.wr = 1'b1;
                    w_wdata = '{task_id: r_new_id, period: r_period,
                                last_run: 32'd0, enabled: r_en};
                end
                MODE_CLEAR: begin
                    w_ctrl.wr = 1'b1;
                    w_wdata.task_id = 16'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= 5'd16;
            r_used  <= '0;
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start && i_mode <= MODE_CLEAR) begin
                        r_state  <= S_WALK;
                        r_mode   <= i_mode;
                        r_now    <= i_now_ms;
                        r_id     <= i_task_id;
                        r_new_id <= i_new_task_id;
                        r_period <= i_period_ms;
                        r_en     <= i_enable;
                        r_pos    <= '0;
                        r_found  <= 1'b0;
                        r_hit    <= '0;
                        r_cnt    <= '0;
                        r_pend   <= 1'b0;
                    end
                end
                S_WALK: begin
                    r_pos <= r_pos + 1'b1;
                    if (w_match) begin
                        r_found <= 1'b1;
                        r_hit   <= r_pos;
                    end
                    // hold each due word back one find so the last gets its flag
                    if (r_mode == MODE_TICK && w_due) begin
                        r_cnt       <= r_cnt + 1'b1;
                        r_pend      <= 1'b1;
                        r_pend_task <= w_head.task_id;
                        r_pend_idx  <= r_pos;
                        if (r_pend) begin
                            r_valid <= 1'b1;
                            r_last  <= 1'b0;
                            r_otask <= r_pend_task;
                            r_oidx  <= 4'(r_pend_idx);
                            r_ostat <= ST_OK;
                        end
                    end
                    if (r_pos == IW'(MAX_SLOTS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b1;
                    r_last  <= 1'b1;
                    r_otask <= r_id;
                    r_oidx  <= '0;
                    r_ostat <= ST_OK;
                    r_pend  <= 1'b0;
                    case (r_mode)
                        MODE_TICK: begin
                            if (r_pend) begin
                                r_otask <= r_pend_task;
                                r_oidx  <= 4'(r_pend_idx);
                            end else begin
                                r_otask <= 16'd0;
                                r_ostat <= ST_NONE;
                            end
                        end
                        MODE_ADD: begin
                            if (r_used < w_lim) begin
                                r_oidx <= 4'(r_used);
                                r_used <= r_used + 1'b1;
                            end else begin
                                r_ostat <= ST_FULL;
                            end
                        end
                        MODE_CLEAR: begin
                            r_otask <= 16'd0;
                            r_used  <= '0;
                        end
                        default: begin
                            if (r_found) begin
                                r_oidx <= 4'(r_hit);
                            end else begin
                                r_ostat <= ST_NOTFOUND;
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_due_task   = r_otask;
    assign o_slot_index = r_oidx;
    assign o_status     = r_ostat;
    assign o_last       = r_last;

`include "periodic_task_slot_scheduler_assert.svh"

    `PTS_ASSERT_IMP(a_used_bound, i_clk, i_rst_n, 1'b1, r_used <= CW'(MAX_SLOTS),
        "used count above table size")
    `PTS_ASSERT_IMP(a_walk_no_last, i_clk, i_rst_n, r_valid && r_ostat != ST_OK,
        r_last, "error word without last flag")
    `PTS_ASSERT_NXT(a_done_word, i_clk, i_rst_n, r_state == S_DONE,
        r_valid && r_last && r_state == S_IDLE, "command ended without final word")
endmodule

// ----- tb/sv/periodic_task_slot_scheduler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_slot_scheduler_tb
// Self-checking bench for the task slot scheduler: a behavioral copy of the
// slot table predicts every result word, and a monitor compares each word
// on the result strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler_tb;
    import pts_pkg::*;

    localparam int SLOTS     = 16;
    localparam int CYC_LIMIT = 400000;
    localparam int DRAIN     = SLOTS + 8;
    localparam logic [2:0] MODE_UNDEF = 3'd7;

    // one result word as the block shows it
    typedef struct packed {
        logic [15:0] due_task;
        logic [3:0]  slot_index;
        logic [1:0]  status;
        logic        last;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic [2:0]  i_mode = '0;
    logic [31:0] i_now_ms = '0;
    logic [15:0] i_task_id = '0;
    logic [15:0] i_new_task_id = '0;
    logic [15:0] i_period_ms = '0;
    logic        i_enable = 1'b0;
    logic        o_busy;
    logic        o_valid;
    logic [15:0] o_due_task;
    logic [3:0]  o_slot_index;
    logic [1:0]  o_status;
    logic        o_last;

    periodic_task_slot_scheduler #(.MAX_SLOTS(SLOTS)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_mode       (i_mode),
        .i_now_ms     (i_now_ms),
        .i_task_id    (i_task_id),
        .i_new_task_id(i_new_task_id),
        .i_period_ms  (i_period_ms),
        .i_enable     (i_enable),
        .o_valid      (o_valid),
        .o_due_task   (o_due_task),
        .o_slot_index (o_slot_index),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the slot table and the limit register.
    logic [15:0] sh_task   [SLOTS];
    logic [15:0] sh_period [SLOTS];
    logic [31:0] sh_last   [SLOTS];
    logic        sh_en     [SLOTS];
    int          sh_used;
    int          sh_limit;

    t_word       pending_words[$];
    int          errors = 0;
    int          cycles = 0;
    logic [31:0] clock_ms = 32'd100;   // running time base for ticks
    logic [15:0] id_pool[8];           // small id set so lookups hit

    // Count cycles and bail out if the run hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYC_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Compare each strobed word against the oldest prediction.
    always @(posedge i_clk) begin
        t_word got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_due_task, o_slot_index, o_status, o_last};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end else begin
                want = pending_words.pop_front();
                if (got.due_task !== want.due_task) begin
                    $display("%0t: due_task exp %h got %h", $time, want.due_task, got.due_task);
                    errors++;
                end
                if (got.slot_index !== want.slot_index) begin
                    $display("%0t: slot_index exp %h got %h", $time, want.slot_index,
                             got.slot_index);
                    errors++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status exp %h got %h", $time, want.status, got.status);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last exp %b got %b", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    function automatic int find_task(logic [15:0] id);
        for (int i = 0; i < sh_used; i++)
            if (sh_task[i] == id) return i;
        return -1;
    endfunction

    // Advance the shadow table by one command and queue its result words.
    function automatic void predict_command(logic [2:0] mode, logic [31:0] now,
            logic [15:0] id, logic [15:0] new_id, logic [15:0] period, logic en);
        int    s;
        int    n;
        int    cap;
        t_word w;
        n = 0;
        case (mode)
            MODE_TICK: begin
                for (int i = 0; i < sh_used; i++) begin
                    if (n < RESULT_CAP && sh_task[i] != 0 && sh_en[i] &&
                            (now - sh_last[i]) > {16'd0, sh_period[i]}) begin
                        sh_last[i] = now;
                        pending_words.push_back('{sh_task[i], i[3:0], ST_OK, 1'b0});
                        n++;
                    end
                end
                if (n == 0) begin
                    pending_words.push_back('{16'd0, 4'd0, ST_NONE, 1'b1});
                end else begin
                    w = pending_words.pop_back();
                    w.last = 1'b1;
                    pending_words.push_back(w);
                end
            end
            MODE_ADD: begin
                cap = (sh_limit > SLOTS) ? SLOTS : sh_limit;
                if (sh_used >= cap) begin
                    pending_words.push_back('{id, 4'd0, ST_FULL, 1'b1});
                end else begin
                    sh_task[sh_used]   = id;
                    sh_period[sh_used] = period;
                    sh_last[sh_used]   = '0;
                    sh_en[sh_used]     = en;
                    pending_words.push_back('{id, 4'(sh_used), ST_OK, 1'b1});
                    sh_used++;
                end
            end
            MODE_DEL, MODE_EN, MODE_PER, MODE_REPL: begin
                s = find_task(id);
                if (s < 0) begin
                    pending_words.push_back('{id, 4'd0, ST_NOTFOUND, 1'b1});
                end else begin
                    case (mode)
                        MODE_DEL: sh_task[s] = '0;
                        MODE_EN:  sh_en[s] = en;
                        MODE_PER: begin
                            sh_period[s] = period;
                            sh_last[s] = now;
                        end
                        default: begin
                            sh_task[s] = new_id;
                            sh_period[s] = period;
                            sh_last[s] = '0;
                            sh_en[s] = en;
                        end
                    endcase
                    pending_words.push_back('{id, 4'(s), ST_OK, 1'b1});
                end
            end
            MODE_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) sh_task[i] = '0;
                sh_used = 0;
                pending_words.push_back('{16'd0, 4'd0, ST_OK, 1'b1});
            end
            default: ;
        endcase
    endfunction

    // Hand one command word to the block after a random gap; hold start
    // through the accepting edge, wait for o_busy to fall, then predict. Start
    // stays high after the accepting edge until the next gap, the next command or an idle wait.
    task automatic send_command(logic [2:0] mode, logic [31:0] now, logic [15:0] id,
            logic [15:0] new_id, logic [15:0] period, logic en);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_now_ms      <= now;
        i_task_id     <= id;
        i_new_task_id <= new_id;
        i_period_ms   <= period;
        i_enable      <= en;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predict_command(mode, now, id, new_id, period, en);
    endtask

    // Drop start, wait for every predicted word, then let the walk finish
    // before a write.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [4:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sh_limit = value;
    endtask

    // Directed: add four slots, hit every mode and corner.
    task automatic test_directed();
        send_command(MODE_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);      // empty: none due
        send_command(MODE_DEL, 32'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);    // not found
        send_command(MODE_ADD, 32'd0, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1);
        send_command(MODE_ADD, 32'd0, 16'd0, 16'd0, 16'd0, 1'b1);       // empty slot, used
        send_command(MODE_ADD, 32'd0, 16'h0001, 16'd0, 16'd0, 1'b1);
        send_command(MODE_ADD, 32'd0, 16'h0002, 16'd0, 16'd5, 1'b0);
        send_command(MODE_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);      // zero elapsed
        send_command(MODE_TICK, 32'd1, 16'd0, 16'd0, 16'd0, 1'b0);
        send_command(MODE_TICK, 32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 1'b0);
        send_command(MODE_EN, 32'd0, 16'h0002, 16'd0, 16'd0, 1'b1);
        send_command(MODE_PER, 32'hFFFF_FFF0, 16'h0001, 16'd0, 16'd3, 1'b0);
        send_command(MODE_TICK, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);      // wrapped elapsed
        send_command(MODE_REPL, 32'd0, 16'd0, 16'hFFFF, 16'd1, 1'b1);   // lookup of id 0
        send_command(MODE_REPL, 32'd0, 16'h0001, 16'h7777, 16'hFFFF, 1'b0);
        send_command(MODE_DEL, 32'd0, 16'hFFFF, 16'd0, 16'd0, 1'b0);
        send_command(MODE_UNDEF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        send_command(MODE_TICK, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 1'b0);
        send_command(MODE_CLEAR, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        send_command(MODE_TICK, 32'h8000_0000, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    // Full table: sixteen appends, one full append, then sixteen due slots in one tick.
    task automatic test_full_table();
        for (int i = 0; i < SLOTS; i++)
            send_command(MODE_ADD, 32'd0, 16'(i + 1), 16'd0, 16'd0, 1'b1);
        send_command(MODE_ADD, 32'd0, 16'h1234, 16'd0, 16'd0, 1'b1);
        send_command(MODE_TICK, 32'd10, 16'd0, 16'd0, 16'd0, 1'b0);
        send_command(MODE_CLEAR, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    // Appends against a given limit, past it by a couple.
    task automatic test_limit(logic [4:0] value);
        write_limit(value);
        send_command(MODE_CLEAR, 32'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        for (int i = 0; i < ((value > SLOTS) ? SLOTS : value) + 2; i++)
            send_command(MODE_ADD, 32'd0, 16'(i + 40), 16'd0, 16'(i), 1'b1);
        send_command(MODE_TICK, 32'd50, 16'd0, 16'd0, 16'd0, 1'b0);
    endtask

    // Random: mostly meaningful commands on a small id pool with a
    // monotonically advancing time, plus raw noise.
    task automatic test_random(int count);
        logic [2:0]  mode;
        logic [31:0] now;
        logic [15:0] id;
        logic [15:0] period;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 40);
            now = clock_ms;
            id = id_pool[$urandom_range(0, 7)];
            period = $urandom_range(0, 60);
            if (pick < 30)      mode = MODE_TICK;
            else if (pick < 55) mode = MODE_ADD;
            else if (pick < 62) mode = MODE_DEL;
            else if (pick < 70) mode = MODE_EN;
            else if (pick < 78) mode = MODE_PER;
            else if (pick < 85) mode = MODE_REPL;
            else if (pick < 88) mode = MODE_CLEAR;
            else if (pick < 90) mode = MODE_UNDEF;
            else begin
                // noise: any field value at all
                mode = $urandom_range(0, 7);
                now = $urandom;
                id = $urandom;
                period = $urandom;
            end
            send_command(mode, now, id, 16'($urandom_range(0, 1) ? id_pool[$urandom_range(0, 7)]
                         : $urandom), period, 1'($urandom_range(0, 3) != 0));
        end
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            sh_task[i] = '0;
            sh_period[i] = '0;
            sh_last[i] = '0;
            sh_en[i] = 1'b0;
        end
        sh_used = 0;
        sh_limit = 16;
        for (int i = 0; i < 8; i++) id_pool[i] = 16'(i * 4097);  // includes empty id
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_limit(5'd1);
        test_limit(5'd0);
        test_limit(5'd31);
        test_limit(5'd6);
        test_random(55);
        test_limit(5'd16);
        test_random(59);

        wait_idle();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
